@@ rtl/pic_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_pkg: shared types and codes of the platform interrupt controller
// Request and region codes, and the command and status bundles exchanged
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package pic_pkg;

	localparam logic [1:0] REQ_IDLE  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	localparam logic [1:0] RGN_PRIO  = 2'd0;
	localparam logic [1:0] RGN_EN    = 2'd1;
	localparam logic [1:0] RGN_THR   = 2'd2;
	localparam logic [1:0] RGN_CLAIM = 2'd3;

	localparam int WORD_BITS = 32;
	localparam int PRIO_W    = 3;
	localparam int SRC_W     = 6;
	localparam int TGT_MAX   = 2;

	// commands from the sequencer
	typedef struct packed {
		logic load;      // capture request, run gateway and access
		logic scan_init; // start arbitration scan
		logic scan_step; // examine one source for each target
		logic claim_fin; // apply claim result, form read data
		logic done;      // latch irq flags
	} cmd_t;

	// status back to the sequencer
	typedef struct packed {
		logic scan_last;  // last source of the scan
		logic is_claim;   // request is a claim read
		logic clr_busy;   // priority memory clearing pass running
	} stat_t;

endpackage

@@ rtl/pic_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_datapath: register file, gateways and arbitration scan
// Holds priorities, enables, thresholds, pending and in-service bits, and
// scans the sources one per cycle to find the best one for every target.
// ----------------------------------------------------------------------------
module pic_datapath #(
	parameter int NUM_SOURCES  = 64,
	parameter int NUM_TARGETS  = 2,
	parameter int MAX_PRIORITY = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pic_pkg::cmd_t       cmd,
	output pic_pkg::stat_t      stat,
	input  logic [1:0]          req_type,
	input  logic [1:0]          region,
	input  logic                target_id,
	input  logic [5:0]          index,
	input  logic [31:0]         write_data,
	input  logic [63:0]         source_levels,
	output logic [31:0]         read_data,
	output logic                access_error,
	output logic [1:0]          irq_to_targets
);

	localparam int NUM_WORDS = (NUM_SOURCES + 31) / 32;
	localparam logic [63:0] VALID_MASK =
		(64'hFFFF_FFFF_FFFF_FFFF >> (64 - NUM_SOURCES)) & ~64'd1;
	localparam logic [2:0] MAXP = 3'(MAX_PRIORITY);

	logic [2:0]  prio_q [64];
	logic [63:0] en_q [2];
	logic [2:0]  thr_q [2];
	logic [63:0] pend_q, insvc_q;

	// priority memory read port and clearing pass
	logic [2:0]  prio_rd_q;
	logic [5:0]  prio_raddr;
	logic        prio_we;
	logic        prd_pend_q;
	logic        clr_busy_q;
	logic [5:0]  clr_idx_q;

	// captured request
	logic        rd_q, wr_q;
	logic [1:0]  rgn_q;
	logic        tgt_q;

	// scan state per target
	logic [5:0]  scan_q;
	logic [5:0]  best_q [2];
	logic [2:0]  bestp_q [2];

	logic        rd, wr, tgt_bad, err;
	logic [2:0]  wsat;
	logic [63:0] pend_gw, wdata_sh, wmask_sh;
	logic [5:0]  cbit;

	assign rd = (req_type == pic_pkg::REQ_READ);
	assign wr = (req_type == pic_pkg::REQ_WRITE);
	assign tgt_bad = (NUM_TARGETS < 2) && target_id;
	assign wsat = (write_data > 32'(MAX_PRIORITY)) ? MAXP : write_data[2:0];
	assign pend_gw = pend_q | (source_levels & VALID_MASK & ~insvc_q);
	assign wdata_sh = index[0] ? {write_data, 32'd0} : {32'd0, write_data};
	assign wmask_sh = index[0] ? {32'hFFFF_FFFF, 32'd0} : {32'd0, 32'hFFFF_FFFF};
	assign cbit = write_data[5:0];

	always_comb begin
		err = 1'b0;
		if (rd || wr) begin
			if (region == pic_pkg::RGN_PRIO)
				err = (7'(index) >= 7'(NUM_SOURCES));
			else
				err = tgt_bad || (region == pic_pkg::RGN_EN &&
					7'(index) >= 7'(NUM_WORDS));
		end
	end

	// read address runs one source ahead of the scan index
	assign prio_raddr = cmd.load ? index :
		(cmd.scan_init ? 6'd1 : scan_q + 6'd1);
	assign prio_we = cmd.load && wr && !err && (region == pic_pkg::RGN_PRIO) &&
		(index != 6'd0);

	assign stat.scan_last = (7'(scan_q) == 7'(NUM_SOURCES - 1));
	assign stat.is_claim  = rd_q && (rgn_q == pic_pkg::RGN_CLAIM);
	assign stat.clr_busy  = clr_busy_q;

	// priority memory: clearing pass after reset, then register writes
	always_ff @(posedge clk) begin
		if (clr_busy_q)
			prio_q[clr_idx_q] <= '0;
		else if (prio_we)
			prio_q[index] <= wsat;
		prio_rd_q <= prio_q[prio_raddr];
	end

	// register accesses, gateway and scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < 2; t++) begin
				en_q[t] <= '0;
				thr_q[t] <= '0;
				best_q[t] <= '0;
				bestp_q[t] <= '0;
			end
			pend_q <= '0;
			insvc_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			rgn_q <= '0;
			tgt_q <= 1'b0;
			scan_q <= '0;
			prd_pend_q <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_idx_q <= '0;
			read_data <= '0;
			access_error <= 1'b0;
			irq_to_targets <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 6'd1;
				if (clr_idx_q == 6'd63) clr_busy_q <= 1'b0;
			end
			if (cmd.load) begin
				pend_q <= pend_gw;
				rd_q <= rd && !err;
				wr_q <= wr && !err;
				rgn_q <= region;
				tgt_q <= target_id;
				access_error <= err;
				read_data <= '0;
				prd_pend_q <= rd && !err && (region == pic_pkg::RGN_PRIO);
				if ((rd || wr) && !err) begin
					unique case (region)
						pic_pkg::RGN_PRIO: ;
						pic_pkg::RGN_EN: begin
							if (rd)
								read_data <= index[0] ? en_q[target_id][63:32]
									: en_q[target_id][31:0];
							else
								en_q[target_id] <= ((en_q[target_id] & ~wmask_sh)
									| wdata_sh) & VALID_MASK;
						end
						pic_pkg::RGN_THR: begin
							if (rd) read_data <= 32'(thr_q[target_id]);
							else thr_q[target_id] <= wsat;
						end
						pic_pkg::RGN_CLAIM: begin
							if (wr && write_data != 32'd0 &&
								write_data < 32'(NUM_SOURCES) &&
								en_q[target_id][cbit])
								insvc_q[cbit] <= 1'b0;
						end
						default: ;
					endcase
				end
			end
			// priority read data comes from the registered memory read in the cycle after the transfer
			if (prd_pend_q) begin
				read_data <= 32'(prio_rd_q);
				prd_pend_q <= 1'b0;
			end
			if (cmd.scan_init) begin
				scan_q <= 6'd1;
				for (int t = 0; t < 2; t++) begin
					best_q[t] <= '0;
					bestp_q[t] <= thr_q[t];
				end
			end
			if (cmd.scan_step) begin
				scan_q <= scan_q + 6'd1;
				for (int t = 0; t < 2; t++) begin
					if (pend_q[scan_q] && en_q[t][scan_q] && prio_rd_q > bestp_q[t]) begin
						best_q[t] <= scan_q;
						bestp_q[t] <= prio_rd_q;
					end
				end
			end
			if (cmd.claim_fin) begin
				read_data <= 32'(best_q[tgt_q]);
				if (best_q[tgt_q] != 6'd0) begin
					pend_q[best_q[tgt_q]] <= 1'b0;
					insvc_q[best_q[tgt_q]] <= 1'b1;
				end
			end
			if (cmd.done) begin
				for (int t = 0; t < 2; t++)
					irq_to_targets[t] <= (t < NUM_TARGETS) && (best_q[t] != 6'd0);
			end
		end
	end

endmodule

@@ rtl/pic_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_ctrl: request sequencer
// Takes a request, runs the datapath through access, a scan for claims,
// a second scan for the irq flags, then offers the result.
// ----------------------------------------------------------------------------
module pic_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output pic_pkg::cmd_t  cmd,
	input  pic_pkg::stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE, S_INIT1, S_SCAN1, S_CLAIM, S_INIT2, S_SCAN2, S_DONE, S_OUT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE) && !stat.clr_busy;

	always_comb begin
		cmd = '0;
		cmd.load      = in_valid && in_ready;
		cmd.scan_init = (state_q == S_INIT1) || (state_q == S_INIT2);
		cmd.scan_step = (state_q == S_SCAN1) || (state_q == S_SCAN2);
		cmd.claim_fin = (state_q == S_CLAIM);
		cmd.done      = (state_q == S_DONE);
	end

	// state register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE:  if (in_valid && in_ready) state_q <= S_INIT1;
				S_INIT1: state_q <= stat.is_claim ? S_SCAN1 : S_INIT2;
				S_SCAN1: if (stat.scan_last) state_q <= S_CLAIM;
				S_CLAIM: state_q <= S_INIT2;
				S_INIT2: state_q <= S_SCAN2;
				S_SCAN2: if (stat.scan_last) state_q <= S_DONE;
				S_DONE: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: if (out_ready) begin
					state_q <= S_IDLE;
					out_valid <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/platform_interrupt_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// platform_interrupt_controller: register-mapped platform interrupt controller
// Level gateways, priority/enable/threshold registers, claim and complete.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | req_type region target_id index
//          |                      | write_data source_levels
//  out     | out_valid / out_ready| read_data access_error irq_to_targets
//
// The result is offered once the scan for the irq flags is done, and a claim runs
// a scan of its own before it: a sequential scan examines one source per cycle.
// A new request waits until the receiver takes the last result: one request at a time.
// After reset a clearing pass zeroes the priority memory; input waits.
// An output stall holds the result and blocks the input.
module platform_interrupt_controller #(
	parameter int NUM_SOURCES  = 64,
	parameter int NUM_TARGETS  = 2,
	parameter int MAX_PRIORITY = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [1:0]  region,
	input  logic        target_id,
	input  logic [5:0]  index,
	input  logic [31:0] write_data,
	input  logic [63:0] source_levels,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic        access_error,
	output logic [1:0]  irq_to_targets
);

	pic_pkg::cmd_t  cmd;
	pic_pkg::stat_t stat;

	// sequencer
	pic_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
	);

	// datapath
	pic_datapath #(
		.NUM_SOURCES(NUM_SOURCES), .NUM_TARGETS(NUM_TARGETS),
		.MAX_PRIORITY(MAX_PRIORITY)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.req_type(req_type), .region(region), .target_id(target_id),
		.index(index), .write_data(write_data), .source_levels(source_levels),
		.read_data(read_data), .access_error(access_error),
		.irq_to_targets(irq_to_targets)
	);

endmodule

@@ rtl/pic_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_checker: port-level checks of the interrupt controller
// Watches handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module pic_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] read_data,
	input logic        access_error
);

	// one request in flight: no input while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");

	// a rejected access reads zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && access_error) |-> (read_data == 32'd0))
		else $error("error result with nonzero data");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(read_data)))
		else $error("result dropped or changed under stall");

	// a transfer in is not followed by a result in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");

endmodule

bind platform_interrupt_controller pic_checker u_pic_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .read_data(read_data),
	.access_error(access_error)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for platform_interrupt_controller
// Sends register accesses with random source levels over a valid/ready
// channel, predicts every result from a model of the gateways, registers and
// claim logic held here, and compares each transfer on the result channel.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [1:0] REQ_RSVD = 2'd3;  // unused request code, acts as idle
	localparam int NSRC = 64;
	localparam int NTGT = 2;
	localparam int PRIO_MAX = 7;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic [31:0] rdata;
		logic        err;
		logic [1:0]  irqs;
	} pic_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [1:0]  region;
	logic        target_id;
	logic [5:0]  index;
	logic [31:0] write_data;
	logic [63:0] source_levels;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] read_data;
	logic        access_error;
	logic [1:0]  irq_to_targets;

	// model state
	logic [2:0]  prio_q [NSRC];
	logic [63:0] enable_q [NTGT];
	logic [2:0]  thresh_q [NTGT];
	logic [63:0] pend_q;
	logic [63:0] serv_q;

	pic_result_t expected_q [$];
	int          claimed_q [$];
	bit          failed;
	int          idle_cycles;

	platform_interrupt_controller i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .region(region), .target_id(target_id),
		.index(index), .write_data(write_data), .source_levels(source_levels),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_data(read_data), .access_error(access_error),
		.irq_to_targets(irq_to_targets)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [2:0] clip_prio(logic [31:0] v);
		return (v > PRIO_MAX) ? 3'(PRIO_MAX) : v[2:0];
	endfunction

	// winning source for a target, 0 when nothing beats the threshold
	function automatic int winner(int t);
		int best;
		int bestp;
		best = 0;
		bestp = thresh_q[t];
		for (int i = 1; i < NSRC; i++) begin
			if (pend_q[i] && enable_q[t][i] && prio_q[i] > bestp) begin
				best = i;
				bestp = prio_q[i];
			end
		end
		return best;
	endfunction

	// apply one access to the model and return what the block should answer
	function automatic pic_result_t apply_access(logic [1:0] rq, logic [1:0] rg,
			logic tg, logic [5:0] ix, logic [31:0] wd, logic [63:0] lv);
		pic_result_t r;
		int s;
		logic [63:0] m;
		r.rdata = '0;
		r.err = 1'b0;
		r.irqs = '0;
		pend_q |= lv & ~64'd1 & ~serv_q;
		if (rq == pic_pkg::REQ_READ || rq == pic_pkg::REQ_WRITE) begin
			if (rg == pic_pkg::RGN_PRIO) begin
				if (rq == pic_pkg::REQ_READ)
					r.rdata = (ix == 0) ? 32'd0 : 32'(prio_q[ix]);
				else if (ix != 0)
					prio_q[ix] = clip_prio(wd);
			end else if (rg == pic_pkg::RGN_EN && ix >= 2) begin
				r.err = 1'b1;
			end else if (rg == pic_pkg::RGN_EN) begin
				if (rq == pic_pkg::REQ_READ) begin
					r.rdata = ix[0] ? enable_q[tg][63:32] : enable_q[tg][31:0];
				end else begin
					m = enable_q[tg];
					if (ix[0])
						m[63:32] = wd;
					else
						m[31:0] = wd;
					enable_q[tg] = m & ~64'd1;
				end
			end else if (rg == pic_pkg::RGN_THR) begin
				if (rq == pic_pkg::REQ_READ)
					r.rdata = 32'(thresh_q[tg]);
				else
					thresh_q[tg] = clip_prio(wd);
			end else if (rq == pic_pkg::REQ_READ) begin
				s = winner(tg);
				if (s != 0) begin
					pend_q[s] = 1'b0;
					serv_q[s] = 1'b1;
				end
				r.rdata = 32'(s);
			end else if (wd != 0 && wd < NSRC) begin
				if (enable_q[tg][wd[5:0]])
					serv_q[wd[5:0]] = 1'b0;
			end
		end
		for (int t = 0; t < NTGT; t++)
			r.irqs[t] = (winner(t) != 0);
		return r;
	endfunction

	// one transfer on the request channel, with a random gap ahead of it
	task automatic send_item(logic [1:0] rq, logic [1:0] rg, logic tg,
			logic [5:0] ix, logic [31:0] wd, logic [63:0] lv);
		int gap;
		pic_result_t r;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		region <= rg;
		target_id <= tg;
		index <= ix;
		write_data <= wd;
		source_levels <= lv;
		do @(posedge clk); while (!in_ready);
		r = apply_access(rq, rg, tg, ix, wd, lv);
		expected_q.push_back(r);
		if (rq == pic_pkg::REQ_READ && rg == pic_pkg::RGN_CLAIM && r.rdata != 0)
			claimed_q.push_back(int'(r.rdata));
	endtask

	function automatic logic [63:0] sparse_levels();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return {$urandom, $urandom};
			default: return {$urandom, $urandom} & {$urandom, $urandom}
				& {$urandom, $urandom};
		endcase
	endfunction

	// result checker with random receiver stalls
	initial begin
		int gap;
		pic_result_t e;
		out_ready <= 1'b0;
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result transfer read_data=%h", $time, read_data);
				failed = 1'b1;
			end else begin
				e = expected_q.pop_front();
				if (read_data !== e.rdata) begin
					$display("%0t: read_data expected %h actual %h", $time, e.rdata, read_data);
					failed = 1'b1;
				end
				if (access_error !== e.err) begin
					$display("%0t: access_error expected %b actual %b", $time, e.err,
						access_error);
					failed = 1'b1;
				end
				if (irq_to_targets !== e.irqs) begin
					$display("%0t: irq_to_targets expected %b actual %b", $time, e.irqs,
						irq_to_targets);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog on transfers of either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic test_priority_regs();
		send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_PRIO, 1'b0, 6'd5, 32'd3, '0);
		send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_PRIO, 1'b0, 6'd63, 32'hFFFF_FFFF,
			'0);  // saturates
		send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_PRIO, 1'b1, 6'd0, 32'd6,
			'0);  // source zero ignored
		send_item(pic_pkg::REQ_READ, pic_pkg::RGN_PRIO, 1'b0, 6'd0, '0, '0);
		send_item(pic_pkg::REQ_READ, pic_pkg::RGN_PRIO, 1'b0, 6'd63, '0, '0);
		send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_PRIO, 1'b0, 6'd1, 32'd8, '0);
	endtask

	task automatic test_enable_regs();
		send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_EN, 1'b0, 6'd0, 32'hFFFF_FFFF,
			'0);  // bit 0 drops
		send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_EN, 1'b1, 6'd1, 32'hFFFF_FFFF, '0);
		send_item(pic_pkg::REQ_READ, pic_pkg::RGN_EN, 1'b0, 6'd0, '0, '0);
		send_item(pic_pkg::REQ_READ, pic_pkg::RGN_EN, 1'b1, 6'd1, '0, '0);
		send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_EN, 1'b0, 6'd63, 32'h1234_5678,
			'0);  // rejected
		send_item(pic_pkg::REQ_READ, pic_pkg::RGN_EN, 1'b1, 6'd2, '0, '0);  // rejected
	endtask

	task automatic test_threshold_regs();
		send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_THR, 1'b1, 6'd9, 32'h8000_0000, '0);
		send_item(pic_pkg::REQ_READ, pic_pkg::RGN_THR, 1'b1, 6'd0, '0, '0);
		send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_THR, 1'b1, 6'd0, 32'd0, '0);
	endtask

	task automatic test_claim_complete();
		send_item(pic_pkg::REQ_READ, pic_pkg::RGN_CLAIM, 1'b0, 6'd0, '0,
			'0);  // nothing pending
		send_item(pic_pkg::REQ_IDLE, pic_pkg::RGN_PRIO, 1'b0, 6'd0, '0,
			64'hFFFF_FFFF_FFFF_FFFF);
		send_item(pic_pkg::REQ_READ, pic_pkg::RGN_CLAIM, 1'b0, 6'd0, '0,
			'0);  // highest enabled priority wins
		send_item(pic_pkg::REQ_READ, pic_pkg::RGN_CLAIM, 1'b1, 6'd0, '0, '0);
		send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_CLAIM, 1'b0, 6'd0, 32'd0,
			'0);  // ignored
		send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_CLAIM, 1'b0, 6'd0, 32'd64,
			'0);  // ignored
		send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_CLAIM, 1'b0, 6'd0, 32'd63,
			64'h8000_0000_0000_0000);
		send_item(REQ_RSVD, pic_pkg::RGN_CLAIM, 1'b1, 6'd0, '0, '0);
	endtask

	task automatic test_random(int n);
		logic [31:0] wd;
		int k;
		for (int i = 0; i < n; i++) begin
			wd = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 9);
			case ($urandom_range(0, 11))
				0, 1: send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_PRIO, 1'($urandom),
					6'($urandom), wd, sparse_levels());
				2: send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_EN, 1'($urandom),
					($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 1)),
					$urandom, sparse_levels());
				3: send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_THR, 1'($urandom),
					6'($urandom), ($urandom_range(0, 3) == 0) ? wd : $urandom_range(0, 3),
					sparse_levels());
				4, 5, 6: send_item(pic_pkg::REQ_READ, pic_pkg::RGN_CLAIM, 1'($urandom),
					6'($urandom), $urandom, sparse_levels());
				7, 8: begin
					if (claimed_q.size() > 0 && $urandom_range(0, 4) != 0) begin
						k = $urandom_range(0, claimed_q.size() - 1);
						wd = claimed_q[k];
						claimed_q.delete(k);
					end else begin
						wd = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 70);
					end
					send_item(pic_pkg::REQ_WRITE, pic_pkg::RGN_CLAIM, 1'($urandom),
						6'($urandom), wd, sparse_levels());
				end
				9, 10: send_item(pic_pkg::REQ_READ, 2'($urandom), 1'($urandom),
					6'($urandom), $urandom, sparse_levels());
				default: send_item(($urandom_range(0, 1) == 0) ? pic_pkg::REQ_IDLE : REQ_RSVD,
					2'($urandom), 1'($urandom), 6'($urandom), $urandom, sparse_levels());
			endcase
		end
	endtask

	initial begin
		int waited;
		failed = 1'b0;
		foreach (prio_q[i]) prio_q[i] = '0;
		foreach (enable_q[i]) enable_q[i] = '0;
		foreach (thresh_q[i]) thresh_q[i] = '0;
		pend_q = '0;
		serv_q = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= pic_pkg::REQ_IDLE;
		region <= pic_pkg::RGN_PRIO;
		target_id <= 1'b0;
		index <= '0;
		write_data <= '0;
		source_levels <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_priority_regs();
		test_enable_regs();
		test_threshold_regs();
		test_claim_complete();
		test_random(1500);

		// drain
		in_valid <= 1'b0;
		waited = 0;
		while (expected_q.size() > 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (200) @(posedge clk);
		if (!failed && expected_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			if (expected_q.size() > 0)
				$display("%0t: %0d expected results never arrived", $time, expected_q.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/pic_pkg.sv
rtl/pic_datapath.sv
rtl/pic_ctrl.sv
rtl/platform_interrupt_controller.sv
rtl/pic_checker.sv
verif/testbench.sv
